// ===== rtl/crlf_line_and_counted_data_framer_defines.svh =====
// Assertion macros shared by the framer RTL.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef CRLF_LINE_AND_COUNTED_DATA_FRAMER_DEFINES_SVH
`define CRLF_LINE_AND_COUNTED_DATA_FRAMER_DEFINES_SVH

// same-cycle implication
`define CLF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/clf_pkg.sv =====
// Types and constants of the CR LF line / counted data framer.
// No dependencies.
package clf_pkg;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_ARM     = 2'd2;

  localparam logic [1:0] DONE_NONE  = 2'd0;
  localparam logic [1:0] DONE_LINE  = 2'd1;
  localparam logic [1:0] DONE_FRAME = 2'd2;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [1:0] buffer_id;
    logic [7:0] data_length;
  } item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       write_valid;
    logic [1:0] write_buffer;
    logic [7:0] write_offset;
    logic [7:0] write_byte;
    logic [1:0] done_kind;
    logic [1:0] done_buffer;
    logic [7:0] done_length;
    logic       dropped;
  } result_t;

endpackage

// ===== rtl/clf_item_if.sv =====
// Input channel of the framer: valid/ready plus the item fields.
// No dependencies.
interface clf_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic [1:0] buffer_id;
  logic [7:0] data_length;

  modport source (output valid, kind, byte_value, buffer_id, data_length, input ready);
  modport sink   (input valid, kind, byte_value, buffer_id, data_length, output ready);
endinterface

// ===== rtl/clf_result_if.sv =====
// Result channel of the framer: valid/ready plus the result fields.
// No dependencies.
interface clf_result_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       write_valid;
  logic [1:0] write_buffer;
  logic [7:0] write_offset;
  logic [7:0] write_byte;
  logic [1:0] done_kind;
  logic [1:0] done_buffer;
  logic [7:0] done_length;
  logic       dropped;

  modport source (output valid, echo_valid, echo_byte, write_valid, write_buffer,
                  write_offset, write_byte, done_kind, done_buffer, done_length,
                  dropped, input ready);
  modport sink   (input valid, echo_valid, echo_byte, write_valid, write_buffer,
                  write_offset, write_byte, done_kind, done_buffer, done_length,
                  dropped, output ready);
endinterface

// ===== rtl/clf_claim.sv =====
// Lowest-free-buffer finder over the busy map.
// No dependencies.
module clf_claim #(
  parameter int COUNT = 4,
  parameter int IDX_W = 2
) (
  input  logic [COUNT-1:0] busy,
  output logic             found,
  output logic [IDX_W-1:0] idx
);

  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = COUNT - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

endmodule

// ===== rtl/clf_core.sv =====
// Framer state and per-item logic: buffer claim/release, line and frame framing.
// Depends on clf_pkg, clf_claim and the assertion macro header.
`include "crlf_line_and_counted_data_framer_defines.svh"

module clf_core #(
  parameter int BUFFER_BYTES = 256,
  parameter int BUFFER_COUNT = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  clf_pkg::item_t  item,
  input  logic            echo_enable,
  output clf_pkg::result_t res
);

  localparam int IDX_W      = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int LINE_LIMIT = (BUFFER_BYTES - 1 > 255) ? 255 : BUFFER_BYTES - 1;
  localparam int OFF_LAST   = BUFFER_BYTES - 1;

  logic [BUFFER_COUNT-1:0] busy_map, busy_map_next;
  logic                    held_valid, held_valid_next;
  logic [IDX_W-1:0]        held_buffer, held_buffer_next;
  logic [7:0]              line_fill, line_fill_next;
  logic [7:0]              previous_byte, previous_byte_next;
  logic [7:0]              frame_length, frame_length_next;
  logic [7:0]              frame_count, frame_count_next;
  logic [7:0]              data_off, data_off_next;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] cur_buf;
  logic [7:0]       fill_inc;
  logic [7:0]       fill_trim;
  logic [7:0]       count_inc;

  clf_claim #(.COUNT(BUFFER_COUNT), .IDX_W(IDX_W)) u_claim (
    .busy  (busy_map),
    .found (free_found),
    .idx   (free_idx)
  );

  always_comb begin
    busy_map_next      = busy_map;
    held_valid_next    = held_valid;
    held_buffer_next   = held_buffer;
    line_fill_next     = line_fill;
    previous_byte_next = previous_byte;
    frame_length_next  = frame_length;
    frame_count_next   = frame_count;
    data_off_next      = data_off;
    res                = '0;
    cur_buf            = held_valid ? held_buffer : free_idx;
    fill_inc           = line_fill + 8'd1;
    fill_trim          = line_fill - 8'd1;
    count_inc          = frame_count + 8'd1;

    case (item.kind)
      clf_pkg::KIND_RELEASE: begin
        if ({3'b000, item.buffer_id} < 5'(BUFFER_COUNT)) begin
          for (int i = 0; i < BUFFER_COUNT; i++) begin
            if (5'(i) == {3'b000, item.buffer_id}) busy_map_next[i] = 1'b0;
          end
        end
      end
      clf_pkg::KIND_ARM: begin
        if (item.data_length != 8'd0) begin
          frame_length_next = item.data_length;
          frame_count_next  = 8'd0;
          data_off_next     = 8'd0;
        end
      end
      clf_pkg::KIND_BYTE: begin
        if (!held_valid && !free_found) begin
          res.dropped = 1'b1;
        end else begin
          if (!held_valid) begin
            for (int i = 0; i < BUFFER_COUNT; i++) begin
              if (IDX_W'(i) == free_idx) busy_map_next[i] = 1'b1;
            end
            held_valid_next  = 1'b1;
            held_buffer_next = free_idx;
          end
          if (frame_length == 8'd0) begin
            // line mode
            res.echo_valid = echo_enable;
            res.echo_byte  = echo_enable ? item.byte_value : 8'd0;
            if (line_fill < 8'(LINE_LIMIT)) begin
              res.write_valid    = 1'b1;
              res.write_buffer   = 2'(cur_buf);
              res.write_offset   = line_fill;
              res.write_byte     = item.byte_value;
              line_fill_next     = fill_inc;
              previous_byte_next = item.byte_value;
              if (line_fill != 8'd0 && previous_byte == clf_pkg::CH_CR &&
                  item.byte_value == clf_pkg::CH_LF) begin
                // CR LF: trim both; post only a non-empty line
                line_fill_next = 8'd0;
                if (fill_trim != 8'd0) begin
                  res.done_kind   = clf_pkg::DONE_LINE;
                  res.done_buffer = 2'(cur_buf);
                  res.done_length = fill_trim;
                  held_valid_next = 1'b0;
                end
              end
            end else begin
              line_fill_next = 8'd0;   // full buffer restarts
            end
          end else begin
            // counted data mode
            res.write_valid  = 1'b1;
            res.write_buffer = 2'(cur_buf);
            res.write_offset = data_off;
            res.write_byte   = item.byte_value;
            frame_count_next = count_inc;
            if ({5'b00000, data_off} == 13'(OFF_LAST) || count_inc == 8'd0) begin
              data_off_next = 8'd0;
            end else begin
              data_off_next = data_off + 8'd1;
            end
            if (count_inc == frame_length) begin
              res.done_kind     = clf_pkg::DONE_FRAME;
              res.done_buffer   = 2'(cur_buf);
              res.done_length   = frame_length;
              held_valid_next   = 1'b0;
              frame_length_next = 8'd0;
              frame_count_next  = 8'd0;
              data_off_next     = 8'd0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_map      <= '0;
      held_valid    <= 1'b0;
      held_buffer   <= '0;
      line_fill     <= 8'd0;
      previous_byte <= 8'd0;
      frame_length  <= 8'd0;
      frame_count   <= 8'd0;
      data_off      <= 8'd0;
    end else if (step) begin
      busy_map      <= busy_map_next;
      held_valid    <= held_valid_next;
      held_buffer   <= held_buffer_next;
      line_fill     <= line_fill_next;
      previous_byte <= previous_byte_next;
      frame_length  <= frame_length_next;
      frame_count   <= frame_count_next;
      data_off      <= data_off_next;
    end
  end

  `CLF_ASSERT_NOW(a_post_has_write, step && res.done_kind != clf_pkg::DONE_NONE,
    res.write_valid, "posted line or frame without a buffer write")
  `CLF_ASSERT_NOW(a_drop_is_silent, step && res.dropped,
    !res.write_valid && !res.echo_valid, "dropped byte was written or echoed")
  `CLF_ASSERT_NEXT(a_post_hands_over, step && res.done_kind != clf_pkg::DONE_NONE,
    !held_valid, "buffer still held after posting")
  `CLF_ASSERT_NEXT(a_frame_clears, step && res.done_kind == clf_pkg::DONE_FRAME,
    frame_length == 8'd0 && frame_count == 8'd0, "frame state not cleared after post")

endmodule

// ===== rtl/crlf_line_and_counted_data_framer.sv =====
// Top level of the CR LF line and counted data framer.
// Depends on clf_pkg, clf_item_if, clf_result_if and clf_core.
//
// Usage:
//   item    - input channel (sink). kind 0 carries a received serial byte,
//             kind 1 frees buffer buffer_id, kind 2 arms counted data mode
//             for data_length raw bytes (zero length is ignored).
//   result  - one result per item: optional echo byte, optional buffer
//             memory write (buffer, offset, byte), a posted line or frame
//             (kind, buffer, length) and a drop flag.
//   cfg_we / cfg_wdata - writes echo_enable; write only while idle.
// Path: an item taken on the item channel is held in the input register,
//   and its result is registered in the result register as soon as that
//   register is free or draining.
// Throughput: one item per cycle while result.ready stays high; the framing
//   state (busy map, fill and frame counters) updates in a single pass as
//   each item leaves the input register.
// Stall: while result.ready is low the result register holds; one more item
//   is taken into the input register, then item.ready drops.
// Reset (rst, synchronous): all buffers free, none held, line mode, counters
//   zero, echo off, both pipeline registers empty.
module crlf_line_and_counted_data_framer #(
  parameter int BUFFER_BYTES = 256,
  parameter int BUFFER_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  clf_item_if.sink            item,
  clf_result_if.source        result,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  logic             echo_enable;

  // input register
  logic             s0_valid;
  clf_pkg::item_t   s0_item;

  // result register
  logic             r_valid;
  clf_pkg::result_t r_data;

  clf_pkg::result_t core_res;
  logic             advance;

  // item leaves the input register when the result register is free or draining
  assign advance    = s0_valid && (!r_valid || result.ready);
  assign item.ready = !s0_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b0;
    end else if (cfg_we) begin
      echo_enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s0_valid <= 1'b1;
    end else if (advance) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s0_item.kind        <= item.kind;
      s0_item.byte_value  <= item.byte_value;
      s0_item.buffer_id   <= item.buffer_id;
      s0_item.data_length <= item.data_length;
    end
  end

  clf_core #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .BUFFER_COUNT (BUFFER_COUNT)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (s0_item),
    .echo_enable (echo_enable),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= 1'b1;
    end else if (result.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_data <= core_res;
    end
  end

  assign result.valid        = r_valid;
  assign result.echo_valid   = r_data.echo_valid;
  assign result.echo_byte    = r_data.echo_byte;
  assign result.write_valid  = r_data.write_valid;
  assign result.write_buffer = r_data.write_buffer;
  assign result.write_offset = r_data.write_offset;
  assign result.write_byte   = r_data.write_byte;
  assign result.done_kind    = r_data.done_kind;
  assign result.done_buffer  = r_data.done_buffer;
  assign result.done_length  = r_data.done_length;
  assign result.dropped      = r_data.dropped;

endmodule

// ===== bench/framer_checker.sv =====
// Self-checking monitor for the CR LF line / counted data framer.
// Depends on clf_pkg, clf_item_if and clf_result_if from the RTL.
// Mirrors the framing state, predicts one result per item, compares in order.
module framer_checker #(
  parameter int BUFFER_BYTES = 256,
  parameter int BUFFER_COUNT = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  logic   cfg_wdata,
  clf_item_if    item_ch,
  clf_result_if  result_ch,
  output int     errors,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LIMIT = (BUFFER_BYTES - 1 > 255) ? 255 : BUFFER_BYTES - 1;

  // mirrored framing state
  logic                    echo_on;
  logic [BUFFER_COUNT-1:0] busy_bits;
  logic                    holding;
  logic [1:0]              hold_buf;
  int                      fill_level;
  logic [7:0]              last_byte;
  logic [7:0]              frame_target;   // 0 means line mode
  logic [7:0]              frame_seen;

  clf_pkg::result_t owed_results[$];
  clf_pkg::result_t got, want;
  clf_pkg::item_t   arrived;
  int               err_count = 0;

  function automatic clf_pkg::result_t frame_step(input clf_pkg::item_t it);
    clf_pkg::result_t r;
    logic             hit;
    r = '0;
    hit = 1'b0;
    case (it.kind)
      clf_pkg::KIND_RELEASE: begin
        if (int'(it.buffer_id) < BUFFER_COUNT) busy_bits[it.buffer_id] = 1'b0;
      end
      clf_pkg::KIND_ARM: begin
        if (it.data_length != 8'd0) begin
          frame_target = it.data_length;
          frame_seen   = 8'd0;
        end
      end
      clf_pkg::KIND_BYTE: begin
        // claim the lowest free buffer when none is held
        if (!holding) begin
          for (int i = 0; i < BUFFER_COUNT; i++) begin
            if (!hit && !busy_bits[i]) begin
              busy_bits[i] = 1'b1;
              holding      = 1'b1;
              hold_buf     = 2'(i);
              hit          = 1'b1;
            end
          end
        end
        if (!holding) begin
          r.dropped = 1'b1;
        end else if (frame_target == 8'd0) begin
          if (echo_on) begin
            r.echo_valid = 1'b1;
            r.echo_byte  = it.byte_value;
          end
          if (fill_level < LINE_LIMIT) begin
            r.write_valid  = 1'b1;
            r.write_buffer = hold_buf;
            r.write_offset = 8'(fill_level);
            r.write_byte   = it.byte_value;
            fill_level++;
            if (fill_level >= 2 && last_byte == clf_pkg::CH_CR &&
                it.byte_value == clf_pkg::CH_LF) begin
              fill_level -= 2;
              if (fill_level > 0) begin
                r.done_kind   = clf_pkg::DONE_LINE;
                r.done_buffer = hold_buf;
                r.done_length = 8'(fill_level);
                holding       = 1'b0;
                fill_level    = 0;
              end
            end
            last_byte = it.byte_value;
          end else begin
            // full buffer: echoed only, fill wraps
            fill_level = 0;
          end
        end else begin
          r.write_valid  = 1'b1;
          r.write_buffer = hold_buf;
          r.write_offset = 8'(int'(frame_seen) % BUFFER_BYTES);
          r.write_byte   = it.byte_value;
          frame_seen     = frame_seen + 8'd1;
          if (frame_seen == frame_target) begin
            r.done_kind   = clf_pkg::DONE_FRAME;
            r.done_buffer = hold_buf;
            r.done_length = frame_target;
            holding       = 1'b0;
            frame_target  = 8'd0;
            frame_seen    = 8'd0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      echo_on      = 1'b0;
      busy_bits    = '0;
      holding      = 1'b0;
      hold_buf     = 2'd0;
      fill_level   = 0;
      last_byte    = 8'd0;
      frame_target = 8'd0;
      frame_seen   = 8'd0;
      owed_results.delete();
    end else begin
      if (cfg_we) echo_on = cfg_wdata;
      // results leave before the item taken at this edge can have one
      if (result_ch.valid && result_ch.ready) begin
        got.echo_valid   = result_ch.echo_valid;
        got.echo_byte    = result_ch.echo_byte;
        got.write_valid  = result_ch.write_valid;
        got.write_buffer = result_ch.write_buffer;
        got.write_offset = result_ch.write_offset;
        got.write_byte   = result_ch.write_byte;
        got.done_kind    = result_ch.done_kind;
        got.done_buffer  = result_ch.done_buffer;
        got.done_length  = result_ch.done_length;
        got.dropped      = result_ch.dropped;
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, got);
          err_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("echo_valid", want.echo_valid, got.echo_valid);
          check_field("echo_byte", want.echo_byte, got.echo_byte);
          check_field("write_valid", want.write_valid, got.write_valid);
          check_field("write_buffer", want.write_buffer, got.write_buffer);
          check_field("write_offset", want.write_offset, got.write_offset);
          check_field("write_byte", want.write_byte, got.write_byte);
          check_field("done_kind", want.done_kind, got.done_kind);
          check_field("done_buffer", want.done_buffer, got.done_buffer);
          check_field("done_length", want.done_length, got.done_length);
          check_field("dropped", want.dropped, got.dropped);
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        arrived.kind        = item_ch.kind;
        arrived.byte_value  = item_ch.byte_value;
        arrived.buffer_id   = item_ch.buffer_id;
        arrived.data_length = item_ch.data_length;
        owed_results.push_back(frame_step(arrived));
      end
    end
    errors  <= err_count;
    pending <= owed_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the framer testbench: clock, reset, stimulus, stall patterns, verdict.
// Depends on the framer RTL (clf_pkg, both channel interfaces) and framer_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // kind value the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // cycles with no transfer on either channel before the run is called hung;
  // the longest legal quiet stretch is a few sender gaps plus a drain pause
  localparam int QUIET_LIMIT = 400;
  localparam int PHASE_ITEMS = 255;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we;
  logic cfg_wdata;

  int   errors;
  int   pending;
  int   sent = 0;
  int   quiet = 0;
  // when set, neither side inserts gaps: back-to-back stretches
  bit   steady = 1'b0;

  clf_item_if   item_ch ();
  clf_result_if result_ch ();

  crlf_line_and_counted_data_framer dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  framer_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_ch   (item_ch),
    .result_ch (result_ch),
    .errors    (errors),
    .pending   (pending)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One item transfer. An optional gap first, then valid held until the
  // block takes it. valid is only lowered by the next call or by drain,
  // always in the same time step as the transfer, so nothing is sent twice.
  task automatic push_item(input logic [1:0] k, input logic [7:0] b,
                           input logic [1:0] id, input logic [7:0] len);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.kind        <= k;
    item_ch.byte_value  <= b;
    item_ch.buffer_id   <= id;
    item_ch.data_length <= len;
    do @(posedge clk); while (!item_ch.ready);
    sent++;
  endtask

  // Unused fields carry random values so the block is seen to ignore them.
  task automatic push_byte(input logic [7:0] b);
    push_item(clf_pkg::KIND_BYTE, b, 2'($urandom), 8'($urandom));
  endtask

  task automatic push_release(input logic [1:0] id);
    push_item(clf_pkg::KIND_RELEASE, 8'($urandom), id, 8'($urandom));
  endtask

  task automatic push_arm(input logic [7:0] len);
    push_item(clf_pkg::KIND_ARM, 8'($urandom), 2'($urandom), len);
  endtask

  task automatic push_line(input int n);
    repeat (n) push_byte(8'($urandom));
    push_byte(clf_pkg::CH_CR);
    push_byte(clf_pkg::CH_LF);
  endtask

  task automatic push_frame(input int n);
    push_arm(8'(n));
    repeat (n) push_byte(8'($urandom));
  endtask

  // Stop sending and wait until every expected result has come back, plus
  // a margin. pending is registered, hence the first edge.
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only called with the block drained.
  task automatic set_echo(input logic on);
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Free every buffer and leave counted mode: a one-byte frame replaces
  // any pending frame count and posts on its own.
  task automatic resync();
    for (int i = 0; i < 4; i++) push_release(2'(i));
    push_arm(8'd1);
    push_byte(8'($urandom));
  endtask

  // Mostly well-formed traffic: CR LF lines, armed frames, buffer releases,
  // with some noise items of any kind mixed in.
  task automatic random_traffic(input int quota);
    int start;
    int pick;
    start = sent;
    while (sent - start < quota) begin
      if ($urandom_range(0, 29) == 0) steady = ~steady;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        push_line($urandom_range(0, 10));
      end else if (pick < 60) begin
        push_frame($urandom_range(1, 16));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3)) push_release(2'($urandom));
      end else begin
        push_item(2'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // Result side: a fresh stall draw for every result.
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin
    item_ch.valid       <= 1'b0;
    item_ch.kind        <= clf_pkg::KIND_BYTE;
    item_ch.byte_value  <= 8'd0;
    item_ch.buffer_id   <= 2'd0;
    item_ch.data_length <= 8'd0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, echo on ----
    set_echo(1'b1);
    // line "00 FF" in buffer 0, posted with length 2
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(clf_pkg::CH_CR);
    push_byte(clf_pkg::CH_LF);
    // empty line: claims buffer 1, not posted, buffer stays held
    push_byte(clf_pkg::CH_CR);
    push_byte(clf_pkg::CH_LF);
    // free buffer 0, free an idle buffer, and an item of unused kind
    push_release(2'd0);
    push_release(2'd3);
    push_item(KIND_UNUSED, 8'hFF, 2'd3, 8'hFF);
    // zero length arm is ignored; a second arm replaces the first;
    // CR LF inside a frame is plain data
    push_arm(8'd0);
    push_arm(8'd3);
    push_arm(8'd2);
    push_byte(clf_pkg::CH_CR);
    push_byte(clf_pkg::CH_LF);
    // one-byte frame claims the lowest free buffer (0)
    push_arm(8'd1);
    push_byte(8'hA5);
    // fill buffers 2 and 3, then a byte with no buffer free is dropped
    push_byte(8'h41);
    push_byte(clf_pkg::CH_CR);
    push_byte(clf_pkg::CH_LF);
    push_byte(8'h42);
    push_byte(clf_pkg::CH_CR);
    push_byte(clf_pkg::CH_LF);
    push_byte(8'h5A);
    for (int i = 0; i < 4; i++) push_release(2'(i));

    // ---- random phases; drained at every boundary (sender holds off
    // until all results are back), echo setting alternates ----
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      set_echo(phase[0]);
      if (phase == 1) begin
        // a line past the buffer limit: fill wraps to zero
        resync();
        push_line($urandom_range(256, 262));
      end else if (phase == 2) begin
        // longest counted frame
        resync();
        push_frame(255);
      end
      random_traffic(PHASE_ITEMS);
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
